[hdl/frb_pkg.sv]
// ----------------------------------------------------------------------------
// frb_pkg
// Shared constants, tables and types of the flat-earth range and bearing unit.
// ----------------------------------------------------------------------------
package frb_pkg;

  typedef enum logic [1:0] {
    REG_CENTER_LON   = 2'd0,
    REG_CENTER_LAT   = 2'd1,
    REG_EARTH_RADIUS = 2'd2
  } cfg_reg_t;

  // pi/180 in Q32
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;
  localparam logic [29:0] RANGE_MAX   = 30'd1073741823;

  localparam int ATAN_ENTRIES = 40;

  // truncated arctangent of 2^-i, Q30
  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001,
    30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0, 30'h0
  };

  // scaled offset magnitudes and signs of one point
  typedef struct packed {
    logic [31:0] ux;
    logic [31:0] uy;
    logic        dx_neg;
    logic        dy_neg;
  } offs_t;

endpackage

[hdl/flat_earth_range_bearing_unit.sv]
// ----------------------------------------------------------------------------
// flat_earth_range_bearing_unit: one transaction per cycle while the output buffer
// has room, set by the pipelined CORDICs; the pipeline stalls while the buffer is full.
// After reset or any config write, in_ready stays low until the settle counter
// runs out, while the cosine pipeline settles; synchronous active-high reset.
// ----------------------------------------------------------------------------
module flat_earth_range_bearing_unit import frb_pkg::*; #(
  parameter int CORDIC_STAGES = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [28:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [28:0] point_lon,
  input  logic signed [27:0] point_lat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [29:0]        range_out,
  output logic [30:0]        bearing_out
);

  localparam int NS     = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int LAT_R  = 35;
  localparam int LAT_B  = NS + 4;
  localparam int DLY_R  = (LAT_B > LAT_R) ? LAT_B - LAT_R : 0;
  localparam int DLY_B  = (LAT_R > LAT_B) ? LAT_R - LAT_B : 0;
  localparam int SETTLE = NS + 2;
  localparam int SW     = $clog2(SETTLE + 1);

  logic signed [28:0] center_lon;
  logic signed [27:0] center_lat;
  logic        [22:0] earth_radius;
  logic      [SW-1:0] settle;

  logic               en;
  logic signed [32:0] cos_q30;

  logic               p1_vld;
  logic signed [29:0] p1_dlon;
  logic signed [28:0] p1_dlat;
  logic        [29:0] mag_lon;
  logic        [28:0] mag_lat;
  logic        [56:0] prod_lon;
  logic        [56:0] prod_lat;

  logic               p2_vld;
  logic        [31:0] p2_rx;
  logic        [31:0] p2_ry;
  logic               p2_xneg;
  logic               p2_yneg;
  logic        [54:0] sc_x;
  logic        [54:0] sc_y;

  logic               p3_vld;
  logic        [30:0] p3_ux;
  logic        [30:0] p3_uy;
  logic               p3_xneg;
  logic               p3_yneg;
  logic        [32:0] cos_mag;
  logic        [64:0] prod_c;

  logic               p4_vld;
  offs_t              p4_offs;

  logic               sq_vld;
  logic        [29:0] sq_range;
  logic        [30:0] at_bearing;
  logic        [30:0] res_range_vld;
  logic        [30:0] res_bearing;

  logic               push;
  logic               pop;
  logic        [60:0] obuf [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic        [1:0]  count;

  assign cfg_ready = 1'b1;
  assign en        = (count != 2'd2);
  assign in_ready  = en && (settle == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_lon   <= '0;
      center_lat   <= '0;
      earth_radius <= 23'd6378206;
      settle       <= SW'(SETTLE);
    end else begin
      if (cfg_valid && cfg_ready) begin
        settle <= SW'(SETTLE);
        unique case (cfg_reg_t'(cfg_index))
          REG_CENTER_LON:   center_lon   <= cfg_data;
          REG_CENTER_LAT:   center_lat   <= cfg_data[27:0];
          REG_EARTH_RADIUS: earth_radius <= cfg_data[22:0];
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - SW'(1);
      end
    end
  end

  frb_cos_cordic #(.STAGES(NS)) u_cos (
    .clk        (clk),
    .center_lat (center_lat),
    .cos_q30    (cos_q30)
  );

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= in_valid && in_ready;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  always_comb begin
    mag_lon  = p1_dlon[29] ? 30'(-p1_dlon) : 30'(p1_dlon);
    mag_lat  = p1_dlat[28] ? 29'(-p1_dlat) : 29'(p1_dlat);
    prod_lon = 57'(mag_lon) * 57'(DEG2RAD_Q32) + (57'(1) << 23);
    prod_lat = 57'(mag_lat) * 57'(DEG2RAD_Q32) + (57'(1) << 23);
    sc_x     = 55'(p2_rx) * 55'(earth_radius) + (55'(1) << 23);
    sc_y     = 55'(p2_ry) * 55'(earth_radius) + (55'(1) << 23);
    cos_mag  = cos_q30[32] ? 33'(-cos_q30) : 33'(cos_q30);
    prod_c   = 65'(p3_ux) * 65'(cos_mag) + (65'(1) << 29);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_dlon <= 30'(point_lon) - 30'(center_lon);
      p1_dlat <= 29'(point_lat) - 29'(center_lat);

      p2_rx   <= prod_lon[55:24];
      p2_ry   <= prod_lat[55:24];
      p2_xneg <= p1_dlon[29];
      p2_yneg <= p1_dlat[28];

      p3_ux   <= sc_x[54:24];
      p3_uy   <= sc_y[54:24];
      p3_xneg <= p2_xneg;
      p3_yneg <= p2_yneg;

      p4_offs.ux     <= prod_c[61:30];
      p4_offs.uy     <= 32'(p3_uy);
      p4_offs.dx_neg <= p3_xneg ^ cos_q30[32];
      p4_offs.dy_neg <= p3_yneg;
    end
  end

  frb_isqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (p4_vld),
    .offs      (p4_offs),
    .out_vld   (sq_vld),
    .range_val (sq_range)
  );

  frb_atan_cordic #(.STAGES(NS)) u_atan (
    .clk     (clk),
    .en      (en),
    .offs    (p4_offs),
    .bearing (at_bearing)
  );

  frb_delay #(.WIDTH(31), .DEPTH(DLY_R)) u_dly_range (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   ({sq_vld, sq_range}),
    .q   (res_range_vld)
  );

  frb_delay #(.WIDTH(31), .DEPTH(DLY_B)) u_dly_bearing (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (at_bearing),
    .q   (res_bearing)
  );

  // two-entry output buffer keeps the pipeline moving while a result waits
  assign push = en && res_range_vld[30];
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) obuf[wr_ptr] <= {res_range_vld[29:0], res_bearing};
  end

  assign out_valid   = (count != 2'd0);
  assign range_out   = obuf[rd_ptr][60:31];
  assign bearing_out = obuf[rd_ptr][30:0];

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken before cosine settled");

  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bearing_out != 31'd0) && (bearing_out <= TWO_PI_Q28))
    else $error("bearing outside (0, 2pi]");
`endif

endmodule

[hdl/frb_delay.sv]
// ----------------------------------------------------------------------------
// frb_delay
// Stallable delay line used to line up the range and bearing paths.
// ----------------------------------------------------------------------------
module frb_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  if (DEPTH == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [WIDTH-1:0] pipe [DEPTH];

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int i = 0; i < DEPTH; i++) pipe[i] <= '0;
      end else if (en) begin
        pipe[0] <= d;
        for (int i = 1; i < DEPTH; i++) pipe[i] <= pipe[i-1];
      end
    end

    assign q = pipe[DEPTH-1];
  end

endmodule

[hdl/frb_cos_cordic.sv]
// ----------------------------------------------------------------------------
// frb_cos_cordic
// Free-running rotation CORDIC giving cos(center latitude) in Q30.
// ----------------------------------------------------------------------------
module frb_cos_cordic import frb_pkg::*; #(
  parameter int STAGES = 28
) (
  input  logic               clk,
  input  logic signed [27:0] center_lat,
  output logic signed [32:0] cos_q30
);

  logic        [27:0]  lat_mag;
  logic        [54:0]  ang_prod;
  logic        [32:0]  ang;
  logic                fold;
  logic signed [33:0]  z_init;

  logic signed [33:0]  z0;
  logic                neg0;

  logic signed [32:0]  x_s [STAGES];
  logic signed [32:0]  y_s [STAGES];
  logic signed [33:0]  z_s [STAGES];
  logic                n_s [STAGES];

  always_comb begin
    lat_mag  = center_lat[27] ? 28'(-center_lat) : 28'(center_lat);
    ang_prod = 55'(lat_mag) * 55'(DEG2RAD_Q32) + (55'(1) << 21);
    ang      = ang_prod[54:22];
    // beyond a right angle use cos(a) = -cos(pi - a)
    fold     = ang > 33'(HALF_PI_Q30);
    z_init   = fold ? 34'(34'(PI_Q30) - 34'(ang)) : 34'(ang);
  end

  always_ff @(posedge clk) begin
    z0   <= z_init;
    neg0 <= fold;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [32:0] xi;
    logic signed [32:0] yi;
    logic signed [33:0] zi;
    logic               ni;

    if (i == 0) begin : g_first
      assign xi = 33'(GAIN_Q30);
      assign yi = '0;
      assign zi = z0;
      assign ni = neg0;
    end else begin : g_rest
      assign xi = x_s[i-1];
      assign yi = y_s[i-1];
      assign zi = z_s[i-1];
      assign ni = n_s[i-1];
    end

    always_ff @(posedge clk) begin
      if (zi >= 0) begin
        x_s[i] <= xi - (yi >>> i);
        y_s[i] <= yi + (xi >>> i);
        z_s[i] <= zi - 34'(ATAN_Q30[i]);
      end else begin
        x_s[i] <= xi + (yi >>> i);
        y_s[i] <= yi - (xi >>> i);
        z_s[i] <= zi + 34'(ATAN_Q30[i]);
      end
      n_s[i] <= ni;
    end
  end

  always_ff @(posedge clk) begin
    cos_q30 <= n_s[STAGES-1] ? -x_s[STAGES-1] : x_s[STAGES-1];
  end

endmodule

[hdl/frb_atan_cordic.sv]
// ----------------------------------------------------------------------------
// frb_atan_cordic
// Normalizing vectoring CORDIC giving the azimuth in (0, 2pi], 2^-28 rad.
// ----------------------------------------------------------------------------
module frb_atan_cordic import frb_pkg::*; #(
  parameter int STAGES = 28
) (
  input  logic        clk,
  input  logic        en,
  input  offs_t       offs,
  output logic [30:0] bearing
);

  typedef struct packed {
    logic               special;
    logic signed [33:0] spec_theta;
    logic signed [33:0] base;
  } brg_ctl_t;

  // first normalize step and axis cases
  brg_ctl_t           ctl_in;
  logic        [40:0] m1;
  logic        [40:0] x1;
  logic        [40:0] y1;

  brg_ctl_t           n1_ctl;
  logic        [40:0] n1_m;
  logic        [40:0] n1_x;
  logic        [40:0] n1_y;
  logic               n1_yneg;

  logic        [40:0] m2;
  logic        [40:0] x2;
  logic        [40:0] y2;

  brg_ctl_t           n2_ctl;
  logic signed [43:0] n2_x;
  logic signed [43:0] n2_y;

  logic signed [43:0] x_s   [STAGES];
  logic signed [43:0] y_s   [STAGES];
  logic signed [33:0] z_s   [STAGES];
  brg_ctl_t           ctl_s [STAGES];

  logic signed [33:0] theta;
  logic signed [35:0] wrap;
  logic        [33:0] bq;

  always_comb begin
    ctl_in.special = (offs.ux == '0) || (offs.uy == '0);
    if (offs.ux == '0) begin
      ctl_in.spec_theta = (offs.dy_neg && offs.uy != '0) ? 34'(PI_Q30) : '0;
    end else begin
      ctl_in.spec_theta = offs.dx_neg ? 34'(34'(0) - 34'(HALF_PI_Q30))
                                      : 34'(HALF_PI_Q30);
    end
    if (offs.dy_neg) begin
      ctl_in.base = offs.dx_neg ? 34'(34'(0) - 34'(PI_Q30)) : 34'(PI_Q30);
    end else begin
      ctl_in.base = '0;
    end

    m1 = (offs.ux > offs.uy) ? 41'(offs.ux) : 41'(offs.uy);
    x1 = 41'(offs.uy);
    y1 = 41'(offs.ux);
    if (m1[40:9] == '0) begin
      m1 = m1 << 32; x1 = x1 << 32; y1 = y1 << 32;
    end
    if (m1[40:25] == '0) begin
      m1 = m1 << 16; x1 = x1 << 16; y1 = y1 << 16;
    end
    if (m1[40:33] == '0) begin
      m1 = m1 << 8; x1 = x1 << 8; y1 = y1 << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_ctl  <= ctl_in;
      n1_m    <= m1;
      n1_x    <= x1;
      n1_y    <= y1;
      n1_yneg <= offs.dx_neg ^ offs.dy_neg;
    end
  end

  always_comb begin
    m2 = n1_m;
    x2 = n1_x;
    y2 = n1_y;
    if (m2[40:37] == '0) begin
      m2 = m2 << 4; x2 = x2 << 4; y2 = y2 << 4;
    end
    if (m2[40:39] == '0) begin
      m2 = m2 << 2; x2 = x2 << 2; y2 = y2 << 2;
    end
    if (!m2[40]) begin
      m2 = m2 << 1; x2 = x2 << 1; y2 = y2 << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_ctl <= n1_ctl;
      n2_x   <= 44'(x2);
      n2_y   <= n1_yneg ? -44'(y2) : 44'(y2);
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [43:0] xi;
    logic signed [43:0] yi;
    logic signed [33:0] zi;
    brg_ctl_t           ci;

    if (i == 0) begin : g_first
      assign xi = n2_x;
      assign yi = n2_y;
      assign zi = '0;
      assign ci = n2_ctl;
    end else begin : g_rest
      assign xi = x_s[i-1];
      assign yi = y_s[i-1];
      assign zi = z_s[i-1];
      assign ci = ctl_s[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          x_s[i] <= xi + (yi >>> i);
          y_s[i] <= yi - (xi >>> i);
          z_s[i] <= zi + 34'(ATAN_Q30[i]);
        end else begin
          x_s[i] <= xi - (yi >>> i);
          y_s[i] <= yi + (xi >>> i);
          z_s[i] <= zi - 34'(ATAN_Q30[i]);
        end
        ctl_s[i] <= ci;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta <= ctl_s[STAGES-1].special ? ctl_s[STAGES-1].spec_theta
                                       : ctl_s[STAGES-1].base + z_s[STAGES-1];
    end
  end

  // zero and negative angles wrap up by a full turn
  always_comb begin
    if (theta > 0) wrap = 36'(theta) + 36'sd2;
    else           wrap = 36'(36'(theta) + 36'(TWO_PI_Q30) + 36'd2);
    bq = 34'(wrap[35:2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bearing <= (bq > 34'(TWO_PI_Q28)) ? TWO_PI_Q28 : bq[30:0];
    end
  end

endmodule

[hdl/frb_isqrt.sv]
// ----------------------------------------------------------------------------
// frb_isqrt
// Squares, sum and a one-digit-per-stage rounded square root for the range.
// ----------------------------------------------------------------------------
module frb_isqrt import frb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  offs_t       offs,
  output logic        out_vld,
  output logic [29:0] range_val
);

  localparam int DIGITS = 32;

  logic        q1_vld;
  logic [63:0] sq_x;
  logic [63:0] sq_y;
  logic        q2_vld;
  logic [63:0] sum;

  logic [63:0] v_s   [DIGITS];
  logic [63:0] r_s   [DIGITS];
  logic        vld_s [DIGITS];

  logic [32:0] rr;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_vld <= 1'b0;
      q2_vld <= 1'b0;
    end else if (en) begin
      q1_vld <= in_vld;
      q2_vld <= q1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= 64'(offs.ux) * 64'(offs.ux);
      sq_y <= 64'(offs.uy) * 64'(offs.uy);
      sum  <= sq_x + sq_y;
    end
  end

  for (genvar i = 0; i < DIGITS; i++) begin : g_digit
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
    logic [63:0] vi;
    logic [63:0] ri;
    logic        ki;
    logic [63:0] trial;

    if (i == 0) begin : g_first
      assign vi = sum;
      assign ri = '0;
      assign ki = q2_vld;
    end else begin : g_rest
      assign vi = v_s[i-1];
      assign ri = r_s[i-1];
      assign ki = vld_s[i-1];
    end

    assign trial = ri + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (vi >= trial) begin
          v_s[i] <= vi - trial;
          r_s[i] <= (ri >> 1) + BIT;
        end else begin
          v_s[i] <= vi;
          r_s[i] <= ri >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst)     vld_s[i] <= 1'b0;
      else if (en) vld_s[i] <= ki;
    end
  end

  // round to nearest from the remainder
  assign rr = (v_s[DIGITS-1] > r_s[DIGITS-1]) ? r_s[DIGITS-1][32:0] + 33'd1
                                              : r_s[DIGITS-1][32:0];

  always_ff @(posedge clk) begin
    if (en) range_val <= (rr > 33'(RANGE_MAX)) ? RANGE_MAX : rr[29:0];
  end

  always_ff @(posedge clk) begin
    if (rst)     out_vld <= 1'b0;
    else if (en) out_vld <= vld_s[DIGITS-1];
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Streams directed and random points through the range and bearing unit and
// checks each result against an in-bench fixed-point predictor. The center and
// radius registers are reprogrammed between phases, the extremes among them.
// Random idle cycles fall on both channels, the receiver stalls once for a long
// stretch and the sender drains the pipe at every phase change.
// ----------------------------------------------------------------------------
module tb_top;
  import frb_pkg::*;

  localparam int STAGES    = 28;
  localparam int LATENCY   = 39;
  localparam int MAX_CYCLE = 600000;

  class range_bearing_board;
    longint          clon;
    longint          clat;
    longint unsigned radius;
    logic [29:0]     exp_range[$];
    logic [30:0]     exp_bearing[$];
    int              errors;

    function new();
      clon   = 0;
      clat   = 0;
      radius = 6378206;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [28:0] val);
      case (idx)
        REG_CENTER_LON:   clon = longint'(signed'(val));
        REG_CENTER_LAT:   clat = longint'(signed'(val[27:0]));
        REG_EARTH_RADIUS: radius = 64'(val[22:0]);
        default: ;
      endcase
    endfunction

    function longint unsigned magn(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint unsigned to_rad_q28(longint unsigned m);
      longint unsigned k;
      k = 64'(DEG2RAD_Q32);
      return (m * k + 64'd8388608) >> 24;
    endfunction

    function longint cos_of_lat();
      longint unsigned k;
      longint a, x, y, z, xs, ys, at;
      bit neg;
      k   = 64'(DEG2RAD_Q32);
      a   = (magn(clat) * k + 64'd2097152) >> 22;
      neg = 0;
      if (a > longint'(HALF_PI_Q30)) begin
        a   = longint'(PI_Q30) - a;
        neg = 1;
      end
      x = longint'(GAIN_Q30);
      y = 0;
      z = a;
      for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        at = longint'(ATAN_Q30[i]);
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - at;
        end else begin
          x = x + ys; y = y - xs; z = z + at;
        end
      end
      return neg ? -x : x;
    endfunction

    function longint angle_of(longint yv, longint xv);
      longint base, z, xs, ys, at;
      longint unsigned m;
      int s;
      base = 0;
      z    = 0;
      s    = 0;
      if (xv < 0) begin
        base = (yv >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
        xv   = -xv;
        yv   = -yv;
      end
      m = (magn(xv) > magn(yv)) ? magn(xv) : magn(yv);
      while (m < 64'h100_0000_0000) begin
        m = m << 1;
        s++;
      end
      xv = xv <<< s;
      yv = yv <<< s;
      for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
        xs = xv >>> i;
        ys = yv >>> i;
        at = longint'(ATAN_Q30[i]);
        if (yv > 0) begin
          xv = xv + ys; yv = yv - xs; z = z + at;
        end else begin
          xv = xv - ys; yv = yv + xs; z = z - at;
        end
      end
      return base + z;
    endfunction

    function longint unsigned root_rounded(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return (v > r) ? r + 1 : r;
    endfunction

    // predict and queue the result of one accepted point
    function void note_point(logic signed [28:0] lon, logic signed [27:0] lat);
      longint dlon, dlat, c, dx, dy, theta;
      longint unsigned ux, uy, r, b;
      dlon = longint'(lon) - clon;
      dlat = longint'(lat) - clat;
      c    = cos_of_lat();
      ux   = (to_rad_q28(magn(dlon)) * radius + 64'd8388608) >> 24;
      uy   = (to_rad_q28(magn(dlat)) * radius + 64'd8388608) >> 24;
      ux   = (ux * magn(c) + 64'd536870912) >> 30;
      dx   = ((dlon < 0) != (c < 0)) ? -longint'(ux) : longint'(ux);
      dy   = (dlat < 0) ? -longint'(uy) : longint'(uy);
      r    = root_rounded(ux * ux + uy * uy);
      if (r > RANGE_MAX) r = 64'(RANGE_MAX);
      if (dx == 0)
        theta = (dy < 0) ? longint'(PI_Q30) : 0;
      else if (dy == 0)
        theta = (dx > 0) ? longint'(HALF_PI_Q30) : -longint'(HALF_PI_Q30);
      else
        theta = angle_of(dx, dy);
      if (theta > 0)
        b = (theta + 2) >> 2;
      else
        b = (longint'(TWO_PI_Q30) + theta + 2) >> 2;
      if (b > TWO_PI_Q28) b = 64'(TWO_PI_Q28);
      exp_range.push_back(r[29:0]);
      exp_bearing.push_back(b[30:0]);
    endfunction

    function void check_result(logic [29:0] rng, logic [30:0] brg);
      logic [29:0] er;
      logic [30:0] eb;
      if (exp_range.size() == 0) begin
        $error("unexpected result: range_out %0d bearing_out %0d", rng, brg);
        errors++;
        return;
      end
      er = exp_range.pop_front();
      eb = exp_bearing.pop_front();
      if (rng !== er) begin
        $error("range_out: expected %0d, got %0d", er, rng);
        errors++;
      end
      if (brg !== eb) begin
        $error("bearing_out: expected %0d, got %0d", eb, brg);
        errors++;
      end
    endfunction

    function int pending();
      return exp_range.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [28:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [28:0] point_lon;
  logic signed [27:0] point_lat;
  logic               out_valid;
  logic               out_ready;
  logic [29:0]        range_out;
  logic [30:0]        bearing_out;

  range_bearing_board board = new();
  int  cycles = 0;
  int  sent = 0;
  bit  no_idle = 0;
  bit  rx_hold = 0;

  flat_earth_range_bearing_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stalls plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.check_result(range_out, bearing_out);
      out_ready <= !rx_hold && (no_idle || $urandom_range(99) >= 6);
    end
  end

  initial begin
    wait (sent >= 400);
    rx_hold = 1;
    repeat (300) @(posedge clk);
    rx_hold = 0;
  end

  task automatic send_point(logic signed [28:0] lon, logic signed [27:0] lat);
    while (!no_idle && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    point_lon <= lon;
    point_lat <= lat;
    do @(posedge clk); while (!in_ready);
    board.note_point(lon, lat);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [28:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_center(longint lon, longint lat, longint unsigned rad);
    drain();
    write_reg(REG_CENTER_LON, lon[28:0]);
    write_reg(REG_CENTER_LAT, {1'b0, lat[27:0]});
    write_reg(REG_EARTH_RADIUS, {6'd0, rad[22:0]});
  endtask

  // mostly points near the center, some anywhere in the field range
  task automatic random_points(int n);
    longint lon, lat;
    int k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) begin
        k   = $urandom_range(27);
        lon = board.clon + longint'($signed($urandom() & ((1 << k) - 1)))
              - (longint'(1) << (k - 1 < 0 ? 0 : k - 1));
        k   = $urandom_range(26);
        lat = board.clat + longint'($signed($urandom() & ((1 << k) - 1)))
              - (longint'(1) << (k - 1 < 0 ? 0 : k - 1));
        case ($urandom_range(9))
          0: lon = board.clon;
          1: lat = board.clat;
          default: ;
        endcase
        send_point(lon[28:0], lat[27:0]);
      end else begin
        send_point(29'($urandom()), 28'($urandom()));
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_CENTER_LON;
    cfg_data  = '0;
    in_valid  = 1'b0;
    point_lon = '0;
    point_lat = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset values: center at origin, axes and field extremes
    send_point(0, 0);
    send_point(0, -1000);
    send_point(0, 1000);
    send_point(1000, 0);
    send_point(-1000, 0);
    send_point(188743680, 94371840);
    send_point(-188743680, -94371840);
    send_point(29'sh0FFF_FFFF, 28'sh7FF_FFFF);
    send_point(29'sh1000_0000, 28'sh800_0000);
    send_point(29'sh0FFF_FFFF, 28'sh800_0000);
    send_point(1, 1);
    send_point(-1, -1);
    // center near the pole, beyond 90 degrees and zero radius
    set_center(-188743680, 94371840, 7000000);
    send_point(0, 0);
    send_point(-188743680, 94371840);
    send_point(-188743680, 0);
    set_center(1000, -120000000, 6000000);
    send_point(5000, -120000000);
    send_point(-5000, -120000000);
    send_point(1000, 0);
    set_center(0, 0, 0);
    send_point(1234567, -7654321);
    send_point(0, 0);
    set_center(29'h0FFF_FFFF, 28'h800_0000, 23'h7F_FFFF);
    send_point(29'sh1000_0000, 28'sh7FF_FFFF);
    send_point(0, 0);

    set_center(0, 0, 6378206);
    random_points(250);
    set_center(188743680, -94371840, 7000000);
    random_points(200);
    set_center(longint'($urandom_range(377487360)) - 188743680,
               longint'($urandom_range(188743680)) - 94371840,
               64'($urandom_range(7000000, 6000000)));
    no_idle = 1;
    random_points(250);
    no_idle = 0;
    set_center(-188743680, 94371840, 6000000);
    random_points(200);
    set_center(64'($urandom()), 64'($urandom()), 64'($urandom()));
    random_points(200);
    set_center(longint'($urandom_range(377487360)) - 188743680, 50000000, 6378206);
    random_points(200);
    set_center(12345, -1, 6500000);
    random_points(230);

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/frb_pkg.sv
hdl/frb_delay.sv
hdl/frb_cos_cordic.sv
hdl/frb_atan_cordic.sv
hdl/frb_isqrt.sv
hdl/flat_earth_range_bearing_unit.sv
tb/tb_top.sv
